// File: src/pch_pkg.sv
// Package: shared types, constants and CRC helpers for the picture CRC16 hash.
`timescale 1ns / 1ps
package pch_pkg;

  localparam int unsigned CRC_W      = 16;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hffff;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_BITDEPTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PER_COMPONENT = 2'd1;

  typedef struct packed {
    logic high_bitdepth;
    logic per_component;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                end_of_component;
    logic                end_of_picture;
  } in_item_t;

  // Shift one byte into the CRC, MSB first, polynomial CRC_POLY.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [7:0] data_byte);
    logic [CRC_W-1:0] c;
    logic             msb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      msb = c[CRC_W-1];
      c   = {c[CRC_W-2:0], data_byte[i]};
      if (msb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

// File: src/pch_in_if.sv
// Interface: input sample channel.
`timescale 1ns / 1ps
interface pch_in_if;
  logic                          valid;
  logic                          ready;
  logic [pch_pkg::SAMPLE_W-1:0]  sample;
  logic                          end_of_component;
  logic                          end_of_picture;

  modport source (output valid, output sample, output end_of_component,
                  output end_of_picture, input ready);
  modport sink   (input valid, input sample, input end_of_component,
                  input end_of_picture, output ready);
endinterface

// File: src/pch_out_if.sv
// Interface: checksum result channel.
`timescale 1ns / 1ps
interface pch_out_if;
  logic                       valid;
  logic                       ready;
  logic [pch_pkg::CRC_W-1:0]  checksum;
  logic                       picture_done;

  modport source (output valid, output checksum, output picture_done, input ready);
  modport sink   (input valid, input checksum, input picture_done, output ready);
endinterface

// File: src/pch_cfg_if.sv
// Interface: configuration register write channel.
`timescale 1ns / 1ps
interface pch_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pch_pkg::CFG_IDX_W-1:0]  reg_index;
  logic                           wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// File: src/picture_crc16_hash.sv
// Path: the closing input sample is held in the stage-1 register, then its checksum is
// loaded into the registered result, where it waits until the output takes it.
// Throughput: one sample per cycle unless stalled; the CRC update, flush and emit decision are
// combinational. The input stalls only while the held sample must emit into a full result.
// Reset (synchronous, active low) empties both stages, loads the CRC with 0xffff and
// clears both configuration registers.
`timescale 1ns / 1ps
module picture_crc16_hash (
  input  logic   clk,
  input  logic   rst_n,
  pch_in_if.sink    in_ch,
  pch_out_if.source out_ch,
  pch_cfg_if.sink   cfg_ch
);
  import pch_pkg::*;

  cfg_t             cfg;
  in_item_t         s1_item_r;
  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic [CRC_W-1:0] crc_r;
  logic [CRC_W-1:0] crc_nxt;
  logic [CRC_W-1:0] core_crc;
  logic [CRC_W-1:0] core_checksum;
  logic             core_emit;
  logic             s1_adv;
  logic             in_acc;
  logic             out_load;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [CRC_W-1:0] out_checksum_r;
  logic             out_picture_done_r;

  pch_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  pch_crc_core u_core (
    .crc      (crc_r),
    .item     (s1_item_r),
    .cfg      (cfg),
    .crc_next (core_crc),
    .emit     (core_emit),
    .checksum (core_checksum)
  );

  // Advance the held sample unless it must emit into a full result register
  assign s1_adv   = s1_valid_r & (~core_emit | ~out_valid_r | out_ch.ready);
  assign out_load = s1_adv & core_emit;

  assign in_ch.ready = ~s1_valid_r | s1_adv;
  assign in_acc      = in_ch.valid & in_ch.ready;

  assign s1_valid_nxt  = in_acc | (s1_valid_r & ~s1_adv);
  assign crc_nxt       = s1_adv ? core_crc : crc_r;
  assign out_valid_nxt = out_load | (out_valid_r & ~out_ch.ready);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      crc_r       <= CRC_INIT;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      crc_r       <= crc_nxt;
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.sample           <= in_ch.sample;
      s1_item_r.end_of_component <= in_ch.end_of_component;
      s1_item_r.end_of_picture   <= in_ch.end_of_picture;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_checksum_r     <= core_checksum;
      out_picture_done_r <= s1_item_r.end_of_picture;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.checksum     = out_checksum_r;
  assign out_ch.picture_done = out_picture_done_r;

  // Reset empties the pipeline and reloads the CRC
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r && crc_r == CRC_INIT))
    else $error("pipeline not cleared by reset");

  // An emitting sample fills the result register and reloads the CRC
  a_emit_reload: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && crc_r == CRC_INIT))
    else $error("emit did not load result or reload CRC");

  // A stalled sample keeps its payload and the CRC untouched
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_item_r) && $stable(crc_r)))
    else $error("stalled sample or CRC changed");

  // The CRC only moves when a sample is processed
  a_crc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(crc_r))
    else $error("CRC changed without a sample");

endmodule

// File: src/pch_cfg_regs.sv
// Configuration registers: bit depth and checksum granularity.
`timescale 1ns / 1ps
module pch_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  pch_cfg_if.sink       cfg_ch,
  output pch_pkg::cfg_t cfg
);
  import pch_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Always take writes
  assign cfg_ch.ready = 1'b1;

  // Decode the register index; ignore writes past the list
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        REG_HIGH_BITDEPTH: cfg_nxt.high_bitdepth = cfg_ch.wdata;
        REG_PER_COMPONENT: cfg_nxt.per_component = cfg_ch.wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: src/pch_crc_core.sv
// CRC core: hash one sample, decide on emission, flush and reload.
`timescale 1ns / 1ps
module pch_crc_core (
  input  logic [pch_pkg::CRC_W-1:0] crc,
  input  pch_pkg::in_item_t         item,
  input  pch_pkg::cfg_t             cfg,
  output logic [pch_pkg::CRC_W-1:0] crc_next,
  output logic                      emit,
  output logic [pch_pkg::CRC_W-1:0] checksum
);
  import pch_pkg::*;

  logic [CRC_W-1:0] crc_lo;
  logic [CRC_W-1:0] crc_sample;
  logic [CRC_W-1:0] crc_flush;

  // Hash low byte, then high byte when configured
  assign crc_lo     = crc_byte(crc, item.sample[7:0]);
  assign crc_sample = cfg.high_bitdepth ? crc_byte(crc_lo, item.sample[15:8]) : crc_lo;

  // Flush sixteen zero bits
  assign crc_flush  = crc_byte(crc_byte(crc_sample, 8'h00), 8'h00);

  // Picture end also closes a component in per-component mode
  assign emit = cfg.per_component ? (item.end_of_component | item.end_of_picture)
                                  : item.end_of_picture;

  assign checksum = crc_flush;
  assign crc_next = emit ? CRC_INIT : crc_sample;

endmodule
